FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the decimal accumulator machine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check under reset gating
`define DAM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// check that holds through reset as well
`define DAM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/dam_pkg.sv
// ----------------------------------------------------------------------------
// dam_pkg
// Types, codes and constants of the decimal accumulator machine.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int MEM_WORDS_DEF = 100;
  localparam int ADDR_W        = 7;
  localparam int WORD_W        = 32;
  localparam int DW_W          = 15;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 80;

  localparam logic signed [DW_W-1:0]   WORD_MAX = 15'sd9999;
  localparam logic signed [DW_W-1:0]   WORD_MIN = -15'sd9999;
  localparam logic signed [WORD_W-1:0] INSN_MIN = 32'sd1000;
  localparam logic signed [WORD_W-1:0] INSN_MAX = 32'sd4399;
  localparam logic [13:0]              RECIP_100 = 14'd5243;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_EXEC    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_HALT     = 3'd1,
    ST_DIV_ZERO = 3'd2,
    ST_BAD_OP   = 3'd3,
    ST_PC_OVR   = 3'd4,
    ST_REJECT   = 3'd5,
    ST_STOPPED  = 3'd6
  } status_e;

  typedef enum logic [5:0] {
    OP_READ  = 6'd10,
    OP_WRITE = 6'd11,
    OP_LOAD  = 6'd20,
    OP_STORE = 6'd21,
    OP_ADD   = 6'd30,
    OP_SUB   = 6'd31,
    OP_DIV   = 6'd32,
    OP_MUL   = 6'd33,
    OP_BR    = 6'd40,
    OP_BRNEG = 6'd41,
    OP_BRZ   = 6'd42,
    OP_HALT  = 6'd43
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDDATA,
    S_DECODE,
    S_OPRD,
    S_EXEC,
    S_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

FILE: rtl/dam_ram.sv
// ----------------------------------------------------------------------------
// dam_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module dam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/dam_mem.sv
// ----------------------------------------------------------------------------
// dam_mem
// Main memory: RAM plus per-word valid bits so unwritten words read as zero.
// ----------------------------------------------------------------------------
module dam_mem #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dam_pkg::mem_req_t           req_i,
  output logic [dam_pkg::WORD_W-1:0]  rdata_o
);
  import dam_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [MEM_WORDS-1:0] vld_q;
  logic                 rvld_q;
  logic [WORD_W-1:0]    ram_rdata;

  dam_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.we),
    .waddr_i (req_i.waddr[AW-1:0]),
    .wdata_i (req_i.wdata),
    .raddr_i (req_i.raddr[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        vld_q[req_i.waddr[AW-1:0]] <= 1'b1;
      end
      rvld_q <= vld_q[req_i.raddr[AW-1:0]];
    end
  end

  assign rdata_o = rvld_q ? ram_rdata : '0;

endmodule

FILE: rtl/dam_div.sv
// ----------------------------------------------------------------------------
// dam_div
// Signed 32-bit divider, truncating, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dam_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dam_pkg::WORD_W-1:0] dividend_i,
  input  logic [dam_pkg::WORD_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [dam_pkg::WORD_W-1:0] quotient_o
);
  import dam_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] dvs_q, dvs_d;
  logic              neg_q, neg_d;
  logic [WORD_W:0]   shifted;
  logic [WORD_W:0]   diff;

  assign shifted = {rem_q, quo_q[WORD_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i[WORD_W-1] ? (WORD_W'(0) - dividend_i) : dividend_i;
      dvs_d  = divisor_i[WORD_W-1] ? (WORD_W'(0) - divisor_i) : divisor_i;
      neg_d  = dividend_i[WORD_W-1] ^ divisor_i[WORD_W-1];
    end else if (busy_q) begin
      if (!diff[WORD_W]) begin
        rem_d = diff[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[WORD_W-1:0];
        quo_d = {quo_q[WORD_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (WORD_W'(0) - quo_q) : quo_q;

  `DAM_ASSERT(a_start_busy, start_i |=> busy_q, "divider not busy after start")
  `DAM_ASSERT_ALWAYS(a_done_idle, done_q |-> !busy_q, "divider done while busy")

endmodule

FILE: rtl/decimal_accumulator_machine_unit.sv
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_unit
// Decimal-word accumulator machine: load, execute, read and restart commands
// against a word memory held in a synchronous RAM.
// ----------------------------------------------------------------------------
// Channel  Dir  tdata (low bit up)                         tuser
// s_axis   in   address[6:0], data_word[21:7]              command[1:0]
// m_axis   out  status[2:0], out_value[34:3], pc[41:35],   out_valid[0]
//               acc_value[73:42], halted[74]
//
// Load and restart go straight to output, a memory read adds a data read,
// and an instruction runs fetch, decode, operand read, execute and output;
// divide waits in the bit-serial divider between execute and output.
// Reset clears the word valid bits at once: no clearing pass.
// One transfer is processed at a time; a result waits in the output
// register until taken while the next command is accepted.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module decimal_accumulator_machine_unit #(
  parameter int MEM_WORDS = dam_pkg::MEM_WORDS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // address[6:0], data_word[21:7], zero pad
  input  logic [dam_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // command[1:0]
  input  logic [1:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // status[2:0], out_value[34:3], program_counter[41:35],
  // acc_value[73:42], halted[74], zero pad
  output logic [dam_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // out_valid[0]
  output logic [0:0]                     m_axis_tuser
);
  import dam_pkg::*;

  localparam logic [ADDR_W-1:0] LIMIT = ADDR_W'(MEM_WORDS);

  state_e state_q, state_d;

  logic [WORD_W-1:0] acc_q, acc_d;
  logic [ADDR_W-1:0] pc_q, pc_d;
  logic              stop_q, stop_d;

  logic signed [DW_W-1:0] dw_q, dw_d;
  logic [WORD_W-1:0] word_q, word_d;
  logic [5:0]        op_q, op_d;
  logic              op_ok_q, op_ok_d;
  logic [ADDR_W-1:0] opnd_q, opnd_d;

  status_e           res_st_q, res_st_d;
  logic              res_ov_q, res_ov_d;
  logic [WORD_W-1:0] res_val_q, res_val_d;

  logic                  m_tvalid_q, m_tvalid_d;
  logic [OUT_DATA_W-1:0] m_tdata_q, m_tdata_d;
  logic                  m_tuser_q, m_tuser_d;

  mem_req_t          req;
  logic [WORD_W-1:0] mem_rdata;

  logic              div_start, div_done;
  logic [WORD_W-1:0] div_quot;

  logic                   accept, out_free;
  cmd_e                   in_cmd;
  logic [ADDR_W-1:0]      in_addr;
  logic signed [DW_W-1:0] in_dw;
  logic                   in_word_ok, dw_q_ok;
  logic [25:0]            recip_prod;
  logic [12:0]            opnd_wide;
  logic [WORD_W-1:0]      ov;
  logic                   adv;
  logic [ADDR_W-1:0]      nxt;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign out_free   = !m_tvalid_q || m_axis_tready;
  assign in_cmd     = cmd_e'(s_axis_tuser);
  assign in_addr    = s_axis_tdata[ADDR_W-1:0];
  assign in_dw      = s_axis_tdata[ADDR_W+DW_W-1:ADDR_W];
  assign in_word_ok = (in_dw >= WORD_MIN) && (in_dw <= WORD_MAX);
  assign dw_q_ok    = (dw_q >= WORD_MIN) && (dw_q <= WORD_MAX);
  assign recip_prod = mem_rdata[12:0] * RECIP_100;
  assign opnd_wide  = word_q[12:0] - (13'(op_q) * 13'd100);
  assign ov         = (opnd_q < LIMIT) ? mem_rdata : '0;

  assign s_axis_tready = (state_q == S_IDLE);

  dam_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rdata_o (mem_rdata)
  );

  dam_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (acc_q),
    .divisor_i  (ov),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_cmd)
            CMD_READ: state_d = (in_addr < LIMIT) ? S_RDDATA : S_OUT;
            CMD_EXEC: state_d = (stop_q || pc_q >= LIMIT) ? S_OUT : S_DECODE;
            default:  state_d = S_OUT;
          endcase
        end
      end
      S_RDDATA: state_d = S_OUT;
      S_DECODE: state_d = S_OPRD;
      S_OPRD:   state_d = S_EXEC;
      S_EXEC: begin
        if (op_ok_q && op_e'(op_q) == OP_DIV && ov != '0) begin
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV:    state_d = div_done ? S_OUT : S_DIV;
      S_OUT:    state_d = out_free ? S_IDLE : S_OUT;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    acc_d      = acc_q;
    pc_d       = pc_q;
    stop_d     = stop_q;
    dw_d       = dw_q;
    word_d     = word_q;
    op_d       = op_q;
    op_ok_d    = op_ok_q;
    opnd_d     = opnd_q;
    res_st_d   = res_st_q;
    res_ov_d   = res_ov_q;
    res_val_d  = res_val_q;
    m_tvalid_d = m_tvalid_q && !m_axis_tready;
    m_tdata_d  = m_tdata_q;
    m_tuser_d  = m_tuser_q;
    req        = '0;
    req.raddr  = pc_q;
    div_start  = 1'b0;
    adv        = 1'b0;
    nxt        = pc_q + ADDR_W'(1);

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_st_d  = ST_OK;
          res_ov_d  = 1'b0;
          res_val_d = '0;
          dw_d      = in_dw;
          case (in_cmd)
            CMD_LOAD: begin
              if (in_word_ok && in_addr < LIMIT) begin
                req.we    = 1'b1;
                req.waddr = in_addr;
                req.wdata = WORD_W'(in_dw);
              end else begin
                res_st_d = ST_REJECT;
              end
            end
            CMD_READ: begin
              if (in_addr < LIMIT) begin
                req.raddr = in_addr;
              end else begin
                res_st_d = ST_REJECT;
              end
            end
            CMD_RESTART: begin
              acc_d  = '0;
              pc_d   = '0;
              stop_d = 1'b0;
            end
            default: begin
              if (stop_q) begin
                res_st_d = ST_STOPPED;
              end else if (pc_q >= LIMIT) begin
                res_st_d = ST_PC_OVR;
                stop_d   = 1'b1;
              end
            end
          endcase
        end
      end
      S_RDDATA: begin
        res_ov_d  = 1'b1;
        res_val_d = mem_rdata;
      end
      S_DECODE: begin
        word_d  = mem_rdata;
        op_d    = recip_prod[24:19];
        op_ok_d = ($signed(mem_rdata) >= INSN_MIN) && ($signed(mem_rdata) <= INSN_MAX);
      end
      S_OPRD: begin
        opnd_d    = opnd_wide[ADDR_W-1:0];
        req.raddr = opnd_wide[ADDR_W-1:0];
      end
      S_EXEC: begin
        adv = 1'b1;
        if (!op_ok_q) begin
          res_st_d = ST_BAD_OP;
          stop_d   = 1'b1;
          adv      = 1'b0;
        end else begin
          case (op_e'(op_q))
            OP_READ: begin
              if (!dw_q_ok) begin
                res_st_d = ST_REJECT;
                adv      = 1'b0;
              end else if (opnd_q < LIMIT) begin
                req.we    = 1'b1;
                req.waddr = opnd_q;
                req.wdata = WORD_W'(dw_q);
              end
            end
            OP_WRITE: begin
              res_ov_d  = 1'b1;
              res_val_d = ov;
            end
            OP_LOAD:  acc_d = ov;
            OP_STORE: begin
              if (opnd_q < LIMIT) begin
                req.we    = 1'b1;
                req.waddr = opnd_q;
                req.wdata = acc_q;
              end
            end
            OP_ADD: acc_d = acc_q + ov;
            OP_SUB: acc_d = acc_q - ov;
            OP_DIV: begin
              adv = 1'b0;
              if (ov == '0) begin
                res_st_d = ST_DIV_ZERO;
                stop_d   = 1'b1;
              end else begin
                div_start = 1'b1;
              end
            end
            OP_MUL:   acc_d = WORD_W'(acc_q * ov);
            OP_BR:    nxt = opnd_q;
            OP_BRNEG: nxt = acc_q[WORD_W-1] ? opnd_q : pc_q + ADDR_W'(1);
            OP_BRZ:   nxt = (acc_q == '0) ? opnd_q : pc_q + ADDR_W'(1);
            OP_HALT: begin
              res_st_d = ST_HALT;
              stop_d   = 1'b1;
              adv      = 1'b0;
            end
            default: begin
              res_st_d = ST_BAD_OP;
              stop_d   = 1'b1;
              adv      = 1'b0;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          acc_d = div_quot;
          adv   = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          m_tvalid_d = 1'b1;
          m_tuser_d  = res_ov_q;
          m_tdata_d  = {5'b0, stop_q, acc_q, pc_q, res_val_q, res_st_q};
        end
      end
      default: ;
    endcase

    // advance or flag overrun
    if (adv) begin
      if (nxt >= LIMIT) begin
        res_st_d = ST_PC_OVR;
        stop_d   = 1'b1;
      end else begin
        pc_d = nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      acc_q      <= '0;
      pc_q       <= '0;
      stop_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      acc_q      <= acc_d;
      pc_q       <= pc_d;
      stop_q     <= stop_d;
      m_tvalid_q <= m_tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dw_q      <= dw_d;
    word_q    <= word_d;
    op_q      <= op_d;
    op_ok_q   <= op_ok_d;
    opnd_q    <= opnd_d;
    res_st_q  <= res_st_d;
    res_ov_q  <= res_ov_d;
    res_val_q <= res_val_d;
    m_tdata_q <= m_tdata_d;
    m_tuser_q <= m_tuser_d;
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;
  assign m_axis_tuser  = m_tuser_q;

  `DAM_ASSERT(a_pc_range, pc_q < LIMIT, "program counter beyond memory")
  `DAM_ASSERT(a_stop_holds, stop_q && state_q != S_IDLE |=> stop_q, "halt flag dropped")
  `DAM_ASSERT(a_div_exec, div_start |-> state_q == S_EXEC, "divider started outside execute")

endmodule

FILE: tb/dam_checker.sv
// ----------------------------------------------------------------------------
// dam_checker
// Watches both stream channels of the decimal accumulator machine, predicts
// each result from accepted commands and compares it field by field.
// ----------------------------------------------------------------------------
module dam_checker
  import dam_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [1:0]            s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic [0:0]            m_axis_tuser,
  output int                    fail_count_o,
  output int                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Words = MEM_WORDS_DEF;

  typedef struct packed {
    logic [2:0]  status;
    logic        out_valid;
    logic [31:0] out_value;
    logic [6:0]  pc;
    logic [31:0] acc;
    logic        halted;
  } machine_result_t;

  logic [31:0]     mem_q [Words];
  logic [31:0]     acc_q;
  logic [6:0]      pc_q;
  logic            stopped_q;
  machine_result_t result_queue[$];
  int              fails;

  assign fail_count_o = fails;
  assign pending_o    = result_queue.size();

  function automatic logic [31:0] rd_word(int a);
    if (a < 0 || a >= Words) return '0;
    return mem_q[a];
  endfunction

  function automatic logic [31:0] quotient(logic [31:0] a, logic [31:0] d);
    logic [31:0] ma, md, q;
    ma = a[31] ? -a : a;
    md = d[31] ? -d : d;
    q  = ma / md;
    return (a[31] ^ d[31]) ? -q : q;
  endfunction

  function automatic machine_result_t run_command(cmd_e cmd, logic [6:0] addr,
                                                  logic signed [14:0] dw);
    machine_result_t r;
    logic            ok;
    int              w, op, opnd;
    logic [31:0]     m;
    logic [31:0]     nxt;
    logic            adv;
    r  = '0;
    ok = dw >= WORD_MIN && dw <= WORD_MAX;
    case (cmd)
      CMD_LOAD: begin
        if (!ok || addr >= Words) r.status = ST_REJECT;
        else mem_q[addr] = 32'(dw);
      end
      CMD_READ: begin
        if (addr >= Words) r.status = ST_REJECT;
        else begin
          r.out_valid = 1'b1;
          r.out_value = mem_q[addr];
        end
      end
      CMD_RESTART: begin
        acc_q = '0;
        pc_q = '0;
        stopped_q = 1'b0;
      end
      default: begin
        if (stopped_q) r.status = ST_STOPPED;
        else if (pc_q >= Words) begin
          r.status = ST_PC_OVR;
          stopped_q = 1'b1;
        end else begin
          m    = mem_q[pc_q];
          w    = $signed(m);
          op   = w / 100;
          opnd = w % 100;
          nxt  = 32'(pc_q) + 1;
          adv  = 1'b1;
          case (op)
            OP_READ: begin
              if (!ok) begin
                r.status = ST_REJECT;
                adv = 1'b0;
              end else if (opnd >= 0 && opnd < Words) mem_q[opnd] = 32'(dw);
            end
            OP_WRITE: begin
              r.out_valid = 1'b1;
              r.out_value = rd_word(opnd);
            end
            OP_LOAD:  acc_q = rd_word(opnd);
            OP_STORE: if (opnd >= 0 && opnd < Words) mem_q[opnd] = acc_q;
            OP_ADD:   acc_q = acc_q + rd_word(opnd);
            OP_SUB:   acc_q = acc_q - rd_word(opnd);
            OP_DIV: begin
              if (rd_word(opnd) == 0) begin
                r.status = ST_DIV_ZERO;
                stopped_q = 1'b1;
                adv = 1'b0;
              end else acc_q = quotient(acc_q, rd_word(opnd));
            end
            OP_MUL:   acc_q = acc_q * rd_word(opnd);
            OP_BR:    nxt = 32'(opnd);
            OP_BRNEG: if (acc_q[31]) nxt = 32'(opnd);
            OP_BRZ:   if (acc_q == 0) nxt = 32'(opnd);
            OP_HALT: begin
              r.status = ST_HALT;
              stopped_q = 1'b1;
              adv = 1'b0;
            end
            default: begin
              r.status = ST_BAD_OP;
              stopped_q = 1'b1;
              adv = 1'b0;
            end
          endcase
          if (adv) begin
            if (nxt >= Words) begin
              r.status = ST_PC_OVR;
              stopped_q = 1'b1;
            end else pc_q = nxt[6:0];
          end
        end
      end
    endcase
    r.pc     = pc_q;
    r.acc    = acc_q;
    r.halted = stopped_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, exp);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    machine_result_t e;
    if (!rst_ni) begin
      foreach (mem_q[i]) mem_q[i] = '0;
      acc_q = '0;
      pc_q = '0;
      stopped_q = 1'b0;
      fails = 0;
      result_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_queue.size() == 0) report_mismatch("unexpected transfer", '0, '0);
        else begin
          e = result_queue.pop_front();
          if (m_axis_tdata[2:0] != e.status)
            report_mismatch("status", m_axis_tdata[2:0], e.status);
          if (m_axis_tuser[0] != e.out_valid)
            report_mismatch("out_valid", m_axis_tuser[0], e.out_valid);
          if (m_axis_tdata[34:3] != e.out_value)
            report_mismatch("out_value", m_axis_tdata[34:3], e.out_value);
          if (m_axis_tdata[41:35] != e.pc)
            report_mismatch("program_counter", m_axis_tdata[41:35], e.pc);
          if (m_axis_tdata[73:42] != e.acc)
            report_mismatch("acc_value", m_axis_tdata[73:42], e.acc);
          if (m_axis_tdata[74] != e.halted)
            report_mismatch("halted", m_axis_tdata[74], e.halted);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        result_queue.push_back(run_command(cmd_e'(s_axis_tuser), s_axis_tdata[6:0],
                                           s_axis_tdata[21:7]));
    end
  end
endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives command streams into the decimal accumulator machine: directed
// corner programs, then random loaded programs run with restarts, under
// several sender and receiver throttling phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dam_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  int                    fail_count, pending;
  int                    send_idle_pct, recv_stall_pct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  decimal_accumulator_machine_unit dut (.*);

  dam_checker checker_i (.fail_count_o(fail_count), .pending_o(pending), .*);

  always @(negedge clk_i)
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic send(cmd_e cmd, int addr, int dw);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b0, 15'(dw), 7'(addr)};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic int insn(op_e op, int opnd);
    return int'(op) * 100 + opnd;
  endfunction

  function automatic int rand_word();
    op_e ops[12] = '{OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV,
                     OP_MUL, OP_BR, OP_BRNEG, OP_BRZ, OP_HALT};
    int  r;
    r = $urandom_range(99);
    if (r < 70) return insn(ops[$urandom_range(11)], $urandom_range(99));
    if (r < 85) return int'($urandom_range(19998)) - 9999;
    return int'($urandom_range(32767)) - 16384;
  endfunction

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int n;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: field extremes, every opcode but halt, faults
    send(CMD_LOAD, 127, 0);
    send(CMD_LOAD, 0, 16383);
    send(CMD_LOAD, 0, -16384);
    send(CMD_EXEC, 0, 0);
    send(CMD_READ, 100, 0);
    send(CMD_LOAD, 99, -9999);
    send(CMD_READ, 99, 0);
    send(CMD_LOAD, 0, insn(OP_READ, 50));
    send(CMD_LOAD, 1, insn(OP_LOAD, 50));
    send(CMD_LOAD, 2, insn(OP_ADD, 99));
    send(CMD_LOAD, 3, insn(OP_SUB, 50));
    send(CMD_LOAD, 4, insn(OP_MUL, 99));
    send(CMD_LOAD, 5, insn(OP_DIV, 99));
    send(CMD_LOAD, 6, insn(OP_STORE, 60));
    send(CMD_LOAD, 7, insn(OP_WRITE, 60));
    send(CMD_LOAD, 8, insn(OP_BRNEG, 10));
    send(CMD_LOAD, 10, insn(OP_BRZ, 20));
    send(CMD_LOAD, 11, insn(OP_DIV, 70));
    send(CMD_LOAD, 98, insn(OP_BR, 99));
    send(CMD_LOAD, 99, insn(OP_ADD, 0));
    send(CMD_EXEC, 0, 16383);
    send(CMD_EXEC, 0, -9999);
    repeat (11) send(CMD_EXEC, 0, 0);
    send(CMD_RESTART, 127, -1);
    // random programs
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? (phase == 1 ? 59 : 13) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 59 : 13) : 0;
      n = 0;
      while (n < 225) begin
        repeat ($urandom_range(12, 1)) begin
          send(CMD_LOAD, $urandom_range(99) < 95 ? $urandom_range(99) : $urandom_range(127),
               rand_word());
          n++;
        end
        if ($urandom_range(3) == 0) begin
          send(CMD_READ, $urandom_range(127), 0);
          n++;
        end
        send(CMD_RESTART, $urandom_range(127), int'($urandom_range(32767)));
        n++;
        repeat ($urandom_range(20, 3)) begin
          send(CMD_EXEC, $urandom_range(127), $urandom_range(9) == 0 ?
               int'($urandom_range(32767)) - 16384 : int'($urandom_range(19998)) - 9999);
          n++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
